// ----- sv/utf8sc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sc_pkg
// Types and constants shared by the UTF-8 stream checker modules.
// ----------------------------------------------------------------------------
package utf8sc_pkg;

    // Error codes reported with every result.
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_LEAD  = 2'd1,
        ERR_BAD_CONT  = 2'd2,
        ERR_EARLY_END = 2'd3
    } t_err_kind;

    // One input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic       halted;
        logic [7:0] error_total;
        logic       any_error;
        logic [15:0] error_offset;
        logic [31:0] error_line;
        t_err_kind  error_kind;
    } t_result;

    localparam int unsigned ERR_LINE_W   = 32;
    localparam int unsigned ERR_OFFSET_W = 16;

    localparam logic [7:0] ERR_LIMIT_RESET = 8'd10;
    localparam logic [7:0] ERR_COUNT_MAX   = 8'd255;

    localparam logic [7:0] BYTE_NEWLINE = 8'd10;

    // Masks and patterns for sequence bytes.
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_PAT  = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_PAT  = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_PAT  = 8'hf0;

    // Number of continuation bytes a lead byte asks for; zero for a bad lead.
    function automatic logic [1:0] lead_length(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            n = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            n = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            n = 2'd3;
        end
        return n;
    endfunction

endpackage

// ----- sv/utf8sc_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sc_in_reg
// Input register stage: holds one accepted transaction until the core takes it.
// ----------------------------------------------------------------------------
module utf8sc_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  utf8sc_pkg::t_item  i_item,
    input  logic               i_take,
    output logic               o_valid,
    output utf8sc_pkg::t_item  o_item
);

    logic              r_valid;
    logic              n_valid;
    utf8sc_pkg::t_item r_item;
    logic              accept;

    // The slot frees up in the same cycle that the core consumes it.
    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- sv/utf8sc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sc_core
// Decoder state and the per-byte decision; one item is processed per step.
// ----------------------------------------------------------------------------
module utf8sc_core #(
    parameter int unsigned LINE_BITS   = 32,
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  utf8sc_pkg::t_item   i_item,
    input  logic [7:0]          i_error_limit,
    output utf8sc_pkg::t_result o_result
);

    localparam int unsigned LW = (LINE_BITS > utf8sc_pkg::ERR_LINE_W) ?
                                 LINE_BITS : utf8sc_pkg::ERR_LINE_W;
    localparam int unsigned OW = (OFFSET_BITS > utf8sc_pkg::ERR_OFFSET_W) ?
                                 OFFSET_BITS : utf8sc_pkg::ERR_OFFSET_W;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;

    logic [1:0]             r_pending, n_pending;
    logic [1:0]             r_pos, n_pos;
    logic                   r_skip, n_skip;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [7:0]             r_err_cnt, n_err_cnt;
    logic                   r_sticky, n_sticky;
    logic                   r_stop, n_stop;

    logic [LINE_BITS-1:0]   line_inc;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [OW-1:0]          lead_off;
    logic [OW-1:0]          new_off_ext;
    logic [LW-1:0]          line_ext;
    logic [1:0]             lead_len;
    logic                   is_newline;
    logic                   is_cont;
    logic                   count_err;
    utf8sc_pkg::t_err_kind  kind;
    logic [LW-1:0]          eline;
    logic [OW-1:0]          eoff;

    assign line_inc    = (r_line != LINE_MAX) ? r_line + LINE_BITS'(1) : r_line;
    assign off_inc     = (r_off != OFF_MAX) ? r_off + OFFSET_BITS'(1) : r_off;
    assign lead_off    = OW'(r_off) - OW'(r_pos);
    assign new_off_ext = OW'(off_inc);
    assign line_ext    = LW'(r_line);
    assign lead_len    = utf8sc_pkg::lead_length(i_item.data_byte);
    assign is_newline  = (i_item.data_byte == utf8sc_pkg::BYTE_NEWLINE);
    assign is_cont     = ((i_item.data_byte & utf8sc_pkg::CONT_MASK) ==
                          utf8sc_pkg::CONT_PAT);

    always_comb begin
        n_pending = r_pending;
        n_pos     = r_pos;
        n_skip    = r_skip;
        n_line    = r_line;
        n_off     = r_off;
        n_stop    = r_stop;
        kind      = utf8sc_pkg::ERR_NONE;
        eline     = '0;
        eoff      = '0;
        count_err = 1'b0;

        priority if (r_stop) begin
            // Halted: the item leaves everything unchanged.
        end else if (i_item.end_of_stream) begin
            if (r_pending != 2'd0) begin
                kind      = utf8sc_pkg::ERR_EARLY_END;
                eline     = line_ext;
                eoff      = lead_off;
                count_err = 1'b1;
            end
            n_pending = 2'd0;
            n_pos     = 2'd0;
            n_skip    = 1'b0;
        end else if (r_skip) begin
            if (is_newline) begin
                n_skip = 1'b0;
                n_line = line_inc;
                n_off  = '0;
            end
        end else if (r_pending != 2'd0) begin
            n_off = off_inc;
            if (is_cont) begin
                n_pending = r_pending - 2'd1;
                n_pos     = (r_pending == 2'd1) ? 2'd0 : r_pos + 2'd1;
            end else begin
                kind      = utf8sc_pkg::ERR_BAD_CONT;
                eline     = line_ext;
                eoff      = lead_off;
                count_err = 1'b1;
                n_pending = 2'd0;
                n_pos     = 2'd0;
                if (is_newline) begin
                    n_line = line_inc;
                    n_off  = '0;
                end else begin
                    n_skip = 1'b1;
                end
            end
        end else if (r_err_cnt > i_error_limit) begin
            n_stop = 1'b1;
        end else begin
            n_off = off_inc;
            if (is_newline) begin
                n_line = line_inc;
                n_off  = '0;
            end else if (i_item.data_byte[7]) begin
                n_pending = lead_len;
                n_pos     = 2'd0;
                if (lead_len == 2'd0) begin
                    kind      = utf8sc_pkg::ERR_BAD_LEAD;
                    eline     = line_ext;
                    eoff      = new_off_ext;
                    count_err = 1'b1;
                end
            end
        end

        n_err_cnt = r_err_cnt;
        n_sticky  = r_sticky;
        if (count_err) begin
            n_sticky = 1'b1;
            if (r_err_cnt != utf8sc_pkg::ERR_COUNT_MAX) begin
                n_err_cnt = r_err_cnt + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_pos     <= 2'd0;
            r_skip    <= 1'b0;
            r_line    <= LINE_BITS'(1);
            r_off     <= '0;
            r_err_cnt <= 8'd0;
            r_sticky  <= 1'b0;
            r_stop    <= 1'b0;
        end else if (i_step) begin
            r_pending <= n_pending;
            r_pos     <= n_pos;
            r_skip    <= n_skip;
            r_line    <= n_line;
            r_off     <= n_off;
            r_err_cnt <= n_err_cnt;
            r_sticky  <= n_sticky;
            r_stop    <= n_stop;
        end
    end

    always_comb begin
        o_result.error_kind   = kind;
        o_result.error_line   = eline[utf8sc_pkg::ERR_LINE_W-1:0];
        o_result.error_offset = eoff[utf8sc_pkg::ERR_OFFSET_W-1:0];
        o_result.any_error    = n_sticky;
        o_result.error_total  = n_err_cnt;
        o_result.halted       = n_stop;
    end

    // Once halted, the block stays halted until reset.
    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |=> r_stop)
        else $error("halt flag cleared without reset");

    // The error count only ever rises.
    a_count_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_err_cnt >= $past(r_err_cnt)))
        else $error("error count went down");

    // The sticky flag and a non-zero count go together.
    a_sticky_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky == (r_err_cnt != 8'd0))
        else $error("sticky flag disagrees with error count");

    // A skip to end of line never overlaps an open sequence.
    a_skip_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_pending == 2'd0 && r_pos == 2'd0))
        else $error("skip active inside a sequence");

endmodule

// ----- sv/utf8sc_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sc_out_reg
// Result register: holds one finished result until the downstream takes it.
// ----------------------------------------------------------------------------
module utf8sc_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  utf8sc_pkg::t_result i_result,
    input  logic                i_ready,
    output logic                o_valid,
    output logic                o_can_load,
    output utf8sc_pkg::t_result o_result
);

    logic                r_valid;
    logic                n_valid;
    utf8sc_pkg::t_result r_result;

    // A new result may enter while the held one leaves in the same cycle.
    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- sv/utf8_stream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_checker
// Streaming UTF-8 validator with line and offset tracking and an error limit.
//
// Bytes of a text stream arrive one per transaction on the slave stream, with
// tlast marking the end of the stream (no byte is carried then). For every
// input transaction the block returns exactly one result transaction giving
// the error found with that byte (none, bad lead byte, bad continuation byte
// or unexpected end inside a sequence), the line and in-line offset of the
// faulty sequence's lead byte, a sticky error flag, the saturating error count
// and a halt flag. After a bad continuation the rest of the line is skipped.
// Once the error count exceeds the configured limit, the next byte met outside
// a sequence and outside a skipped line halts the block, and every later
// transaction is answered with no error and the halt flag set until reset. The
// block takes one transaction per clock cycle without gaps while results are
// taken. A transaction is held in the input register and then in the result
// register; the decoder state in the core is updated as it moves from the one
// to the other.
// Line and offset counters saturate at LINE_BITS and OFFSET_BITS; the reported
// line and offset are the low 32 and 16 bits. The error limit (reset value 10)
// may be written only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_stream_checker #(
    parameter int unsigned LINE_BITS   = 32,
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration: error limit.
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_stream

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [1:0] error_kind, [33:2] error_line,
                                        // [49:34] error_offset, [50] any_error,
                                        // [58:51] error_total, [59] halted,
                                        // [63:60] zero
);

    logic [7:0]          r_limit;
    utf8sc_pkg::t_item   in_item;
    utf8sc_pkg::t_item   held_item;
    logic                held_valid;
    logic                out_can_load;
    logic                step;
    utf8sc_pkg::t_result core_result;
    utf8sc_pkg::t_result out_result;

    // The error limit register is written directly; no handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= utf8sc_pkg::ERR_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    assign in_item.data_byte     = s_axis_tdata;
    assign in_item.end_of_stream = s_axis_tlast;

    utf8sc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // A held transaction is processed whenever the result register has room,
    // which includes the cycle in which its current result is taken.
    assign step = held_valid && out_can_load;

    utf8sc_core #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (held_item),
        .i_error_limit (r_limit),
        .o_result      (core_result)
    );

    utf8sc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (core_result),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_can_load (out_can_load),
        .o_result   (out_result)
    );

    assign m_axis_tdata = {4'b0000,
                           out_result.halted,
                           out_result.error_total,
                           out_result.any_error,
                           out_result.error_offset,
                           out_result.error_line,
                           out_result.error_kind};

    // Every step must find room in the result register.
    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> out_can_load)
        else $error("step taken with the result register full");

    // A step always leaves a result waiting in the next cycle.
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> m_axis_tvalid)
        else $error("processed transaction produced no result");

    // The input side stalls only while an item is held and cannot move on.
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (held_valid && !out_can_load))
        else $error("input stalled without cause");

endmodule

// ----- tb/sv/utf8_result_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_result_monitor
// Watches both streams of the UTF-8 stream checker and predicts every result.
//
// Each accepted byte or end-of-stream transaction is run through a behavioural
// copy of the decoder. The copy tracks the sequence, skip, line, offset and
// error state and the error limit. The predicted result is queued, and each
// result transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_result_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_bad_lead,
    output int          o_bad_cont,
    output int          o_early_end,
    output logic        o_halted
);

    logic [7:0]                          limit_q;
    logic [1:0]                          owed_conts;
    logic [1:0]                          cont_index;
    logic                                skip_line;
    logic [utf8sc_pkg::ERR_LINE_W-1:0]   line_no;
    logic [utf8sc_pkg::ERR_OFFSET_W-1:0] col_no;
    logic [7:0]                          err_seen;
    logic                                err_flag;
    logic                                stopped;

    utf8sc_pkg::t_result awaited_results[$];

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("[%0t] result %0d: %s is 0x%0h, should be 0x%0h",
                 $time, o_checked, what, got, want);
        o_fail_count++;
    endtask

    task automatic note_fault();
        if (err_seen != utf8sc_pkg::ERR_COUNT_MAX) begin
            err_seen++;
        end
        err_flag = 1'b1;
    endtask

    task automatic next_column();
        if (col_no != '1) begin
            col_no++;
        end
    endtask

    task automatic next_line();
        if (line_no != '1) begin
            line_no++;
        end
        col_no = '0;
    endtask

    // Advance the decoder by one transaction and work out what it reports.
    task automatic decode_byte(input logic [7:0] b, input logic eos,
                               output utf8sc_pkg::t_result res);
        logic [utf8sc_pkg::ERR_OFFSET_W-1:0] lead_col;
        res      = '0;
        lead_col = col_no - utf8sc_pkg::ERR_OFFSET_W'(cont_index);
        if (stopped) begin
            // Halted: nothing changes until reset.
        end else if (eos) begin
            if (owed_conts != 2'd0) begin
                res.error_kind   = utf8sc_pkg::ERR_EARLY_END;
                res.error_line   = line_no;
                res.error_offset = lead_col;
                note_fault();
            end
            owed_conts = '0;
            cont_index = '0;
            skip_line  = 1'b0;
        end else if (skip_line) begin
            if (b == utf8sc_pkg::BYTE_NEWLINE) begin
                skip_line = 1'b0;
                next_line();
            end
        end else if (owed_conts != 2'd0) begin
            next_column();
            if ((b & utf8sc_pkg::CONT_MASK) == utf8sc_pkg::CONT_PAT) begin
                owed_conts--;
                cont_index++;
                if (owed_conts == 2'd0) begin
                    cont_index = '0;
                end
            end else begin
                res.error_kind   = utf8sc_pkg::ERR_BAD_CONT;
                res.error_line   = line_no;
                res.error_offset = lead_col;
                note_fault();
                owed_conts = '0;
                cont_index = '0;
                if (b == utf8sc_pkg::BYTE_NEWLINE) begin
                    next_line();
                end else begin
                    skip_line = 1'b1;
                end
            end
        end else if (err_seen > limit_q) begin
            stopped = 1'b1;
        end else begin
            next_column();
            if (b == utf8sc_pkg::BYTE_NEWLINE) begin
                next_line();
            end else if (b[7]) begin
                if ((b & utf8sc_pkg::LEAD2_MASK) == utf8sc_pkg::LEAD2_PAT) begin
                    owed_conts = 2'd1;
                end else if ((b & utf8sc_pkg::LEAD3_MASK) == utf8sc_pkg::LEAD3_PAT) begin
                    owed_conts = 2'd2;
                end else if ((b & utf8sc_pkg::LEAD4_MASK) == utf8sc_pkg::LEAD4_PAT) begin
                    owed_conts = 2'd3;
                end else begin
                    res.error_kind   = utf8sc_pkg::ERR_BAD_LEAD;
                    res.error_line   = line_no;
                    res.error_offset = col_no;
                    note_fault();
                end
                cont_index = '0;
            end
        end
        res.any_error   = err_flag;
        res.error_total = err_seen;
        res.halted      = stopped;
    endtask

    always @(posedge i_clk) begin
        utf8sc_pkg::t_result got;
        utf8sc_pkg::t_result want;
        utf8sc_pkg::t_result fresh;
        if (!i_rst_n) begin
            limit_q      = utf8sc_pkg::ERR_LIMIT_RESET;
            owed_conts   = '0;
            cont_index   = '0;
            skip_line    = 1'b0;
            line_no      = utf8sc_pkg::ERR_LINE_W'(1);
            col_no       = '0;
            err_seen     = '0;
            err_flag     = 1'b0;
            stopped      = 1'b0;
            awaited_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_bad_lead   = 0;
            o_bad_cont   = 0;
            o_early_end  = 0;
        end else begin
            if (i_cfg_wr_en) begin
                limit_q = i_cfg_wr_data;
            end
            // Results first: a result can never belong to the byte taken in the same cycle.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[59:0];
                if (awaited_results.size() == 0) begin
                    log_mismatch("result with no byte awaiting it", 32'(got), 32'd0);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.error_kind != want.error_kind)
                        log_mismatch("error_kind", 32'(got.error_kind), 32'(want.error_kind));
                    if (got.error_line != want.error_line)
                        log_mismatch("error_line", got.error_line, want.error_line);
                    if (got.error_offset != want.error_offset)
                        log_mismatch("error_offset", 32'(got.error_offset),
                                     32'(want.error_offset));
                    if (got.any_error != want.any_error)
                        log_mismatch("any_error", 32'(got.any_error), 32'(want.any_error));
                    if (got.error_total != want.error_total)
                        log_mismatch("error_total", 32'(got.error_total),
                                     32'(want.error_total));
                    if (got.halted != want.halted)
                        log_mismatch("halted", 32'(got.halted), 32'(want.halted));
                    if (m_axis_tdata[63:60] != 4'd0)
                        log_mismatch("tdata padding", 32'(m_axis_tdata[63:60]), 32'd0);
                    unique case (want.error_kind)
                        utf8sc_pkg::ERR_BAD_LEAD:  o_bad_lead++;
                        utf8sc_pkg::ERR_BAD_CONT:  o_bad_cont++;
                        utf8sc_pkg::ERR_EARLY_END: o_early_end++;
                        default: ;
                    endcase
                    o_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast, fresh);
                awaited_results.push_back(fresh);
            end
        end
        o_pending = awaited_results.size();
        o_halted  = stopped;
    end

endmodule

// ----- tb/sv/utf8_stream_checker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_checker_test
// Self-checking testbench for the UTF-8 stream checker.
//
// The top drives byte and end-of-stream transactions with random gaps while a
// separate process accepts results with random stalls, including long
// hold-offs that back the block up. A directed opening covers the extreme
// byte values, every lead length and every error kind. Random text follows,
// mostly well-formed sequences with a share of broken ones and noise, under
// several error limits. The run ends by forcing the block to halt. The
// monitor module predicts and compares; this module only makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module utf8_stream_checker_test;

    // Item counts at which the two random phases stop.
    localparam int unsigned FIRST_PHASE_END  = 760;
    localparam int unsigned SECOND_PHASE_END = 1520;
    // Length of the receiver's long hold-off, in cycles.
    localparam int unsigned LONG_HOLD        = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_data;
    logic        in_last;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          bad_lead_hits;
    int          bad_cont_hits;
    int          early_end_hits;
    logic        halted_seen;

    int unsigned sent_items = 0;
    int unsigned bytes_sent = 0;
    int unsigned marks_sent = 0;
    bit          send_burst = 1'b0;

    always #4 clk = ~clk;

    utf8_stream_checker u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tlast  (in_last),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data)
    );

    utf8_result_monitor u_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tlast  (in_last),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_bad_lead    (bad_lead_hits),
        .o_bad_cont    (bad_cont_hits),
        .o_early_end   (early_end_hits),
        .o_halted      (halted_seen)
    );

    // Offer one transaction and wait until the block takes it. Valid stays high
    // afterwards, so back-to-back items follow without a gap; it is only dropped
    // when the next item draws a gap. Every forty items the sender decides
    // whether to run a burst with no gaps at all.
    task automatic send_item(input logic [7:0] b, input logic eos);
        int unsigned gap;
        if (sent_items % 40 == 0) begin
            send_burst = ($urandom_range(0, 3) == 0);
        end
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        in_last  <= eos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
        if (eos) begin
            marks_sent++;
        end else begin
            bytes_sent++;
        end
    endtask

    // The byte lane is ignored with an end-of-stream mark, so it carries noise.
    task automatic send_end_mark();
        send_item(8'($urandom), 1'b1);
    endtask

    // A lead byte asking for n continuations (1 to 3), followed by k of them,
    // all with random payload bits.
    task automatic send_sequence(input int unsigned n, input int unsigned k);
        logic [7:0] lead;
        case (n)
            1:       lead = utf8sc_pkg::LEAD2_PAT |
                            (8'($urandom) & ~utf8sc_pkg::LEAD2_MASK);
            2:       lead = utf8sc_pkg::LEAD3_PAT |
                            (8'($urandom) & ~utf8sc_pkg::LEAD3_MASK);
            default: lead = utf8sc_pkg::LEAD4_PAT |
                            (8'($urandom) & ~utf8sc_pkg::LEAD4_MASK);
        endcase
        send_item(lead, 1'b0);
        repeat (k) send_item(utf8sc_pkg::CONT_PAT |
                             (8'($urandom) & ~utf8sc_pkg::CONT_MASK), 1'b0);
    endtask

    // One random piece of text. Most pieces are well formed; the rest are
    // broken sequences, bad lead bytes and raw noise. The error rate is kept
    // low enough that the error count stays under the limits of the random
    // phases, so the block does not halt before the closing part.
    task automatic send_random_unit();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        n    = $urandom_range(1, 3);
        if (pick < 45) begin
            send_item(8'($urandom_range(0, 127)), 1'b0);
        end else if (pick < 70) begin
            send_sequence(n, n);
        end else if (pick < 82) begin
            send_item(utf8sc_pkg::BYTE_NEWLINE, 1'b0);
        end else if (pick < 87) begin
            send_end_mark();
        end else if (pick < 93) begin
            // Broken sequence: cut short by a foreign byte or by the end of stream.
            send_sequence(n, $urandom_range(0, n - 1));
            if ($urandom_range(0, 4) == 0) begin
                send_end_mark();
            end else if ($urandom_range(0, 3) == 0) begin
                send_item(utf8sc_pkg::BYTE_NEWLINE, 1'b0);
            end else begin
                b = 8'($urandom);
                while ((b & utf8sc_pkg::CONT_MASK) == utf8sc_pkg::CONT_PAT) b = 8'($urandom);
                send_item(b, 1'b0);
            end
        end else if (pick < 96) begin
            // Stray continuation byte or one of the never-valid leads.
            if ($urandom_range(0, 1) == 0) begin
                send_item(utf8sc_pkg::CONT_PAT |
                          (8'($urandom) & ~utf8sc_pkg::CONT_MASK), 1'b0);
            end else begin
                send_item(8'($urandom_range(8'hf8, 8'hff)), 1'b0);
            end
        end else begin
            send_item(8'($urandom), 1'b0);
        end
    endtask

    task automatic send_random_text(input int unsigned upto);
        while (sent_items < upto) send_random_unit();
    endtask

    // The limit may only change while the block is idle: stop offering,
    // let every outstanding result drain, allow the pipeline to settle,
    // then write.
    task automatic set_error_limit(input logic [7:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side: a random stall before each result, with relaxed stretches
    // where results are taken at once. Twice in the run the receiver holds
    // off for a long stretch while the sender carries on, so that the block
    // fills up and stops accepting input.
    initial begin : result_sink
        int unsigned taken;
        int unsigned stall;
        bit          relaxed;
        taken   = 0;
        relaxed = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken % 50 == 0) begin
                relaxed = ($urandom_range(0, 3) == 0);
            end
            if (taken == 300 || taken == 1100) begin
                stall = LONG_HOLD;
            end else begin
                stall = relaxed ? 0 : $urandom_range(0, 11);
            end
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    // Watchdog: far beyond the slowest correct run, including both hold-offs.
    initial begin : watchdog
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'd0;
        in_valid    <= 1'b0;
        in_data     <= 8'd0;
        in_last     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset limit of ten errors.
        // Smallest and largest plain bytes, then a newline.
        send_item(8'h00, 1'b0);
        send_item(8'h7f, 1'b0);
        send_item(utf8sc_pkg::BYTE_NEWLINE, 1'b0);
        // Every lead length at the edges of its lead and continuation ranges.
        send_item(8'hc0, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hef, 1'b0);
        send_item(8'hbf, 1'b0);
        send_item(8'hbf, 1'b0);
        send_item(8'hf7, 1'b0);
        repeat (3) send_item(8'hbf, 1'b0);
        // Bad leads: a lone continuation byte, the top byte and the lowest
        // of the five-byte leads.
        send_item(8'h80, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'hf8, 1'b0);
        // A bad continuation starts a skip; a skipped lead byte is ignored
        // and the newline ends the skip.
        send_item(8'hc3, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'he2, 1'b0);
        send_item(utf8sc_pkg::BYTE_NEWLINE, 1'b0);
        // A bad continuation that is itself a newline ends the line at once.
        send_item(8'he2, 1'b0);
        send_item(utf8sc_pkg::BYTE_NEWLINE, 1'b0);
        // End of stream inside a sequence, then end of stream outside one.
        send_item(8'hf0, 1'b0);
        send_item(8'h90, 1'b0);
        send_end_mark();
        send_end_mark();

        // Random text under a middle limit and then under the highest one.
        set_error_limit(8'd127);
        send_random_text(FIRST_PHASE_END);
        set_error_limit(8'd254);
        send_random_text(SECOND_PHASE_END);

        // Closing part: leave the block inside a sequence, drop the limit to
        // zero, and show that neither continuation bytes, skipped bytes nor an
        // end of stream trigger the halt, while the next plain byte does.
        send_end_mark();
        send_item(8'hf0, 1'b0);
        send_item(8'h90, 1'b0);
        set_error_limit(8'd0);
        send_item(8'h9f, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h42, 1'b0);
        send_end_mark();
        send_item(8'h43, 1'b0);
        // Everything from here on is ignored by the halted block.
        repeat (20) send_item(8'($urandom), 1'($urandom_range(0, 1)));

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d byte and %0d end-of-stream transactions under limits 10, 127, 254, 0;",
                 bytes_sent, marks_sent);
        $display("%0d results compared: %0d bad lead, %0d bad continuation, %0d early end, halted %0d.",
                 checked, bad_lead_hits, bad_cont_hits, early_end_hits, halted_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- utf8_stream_checker.f -----
sv/utf8sc_pkg.sv
sv/utf8sc_in_reg.sv
sv/utf8sc_core.sv
sv/utf8sc_out_reg.sv
sv/utf8_stream_checker.sv
tb/sv/utf8_result_monitor.sv
tb/sv/utf8_stream_checker_test.sv
